>>> rtl/scld_pkg.sv
// ----------------------------------------------------------------------------
// scld_pkg
// Types and constants shared by the serial command line decoder modules.
// ----------------------------------------------------------------------------
package scld_pkg;

   localparam logic [7:0] CR_BYTE  = 8'd13;
   localparam int         KW_COUNT = 7;
   localparam int         KW_MAX   = 9;

   typedef enum logic [2:0] {
      CMD_PING      = 3'd0,
      CMD_ID        = 3'd1,
      CMD_MEASURE   = 3'd2,
      CMD_MEMSTATUS = 3'd3,
      CMD_RESET     = 3'd4,
      CMD_RECORD    = 3'd5,
      CMD_GET       = 3'd6
   } command_type;

   // keyword text, left aligned, zero padded
   localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX] = '{
      '{"P", "I", "N", "G", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"I", "D", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"M", "E", "A", "S", "U", "R", "E", 8'h00, 8'h00},
      '{"M", "E", "M", "S", "T", "A", "T", "U", "S"},
      '{"R", "E", "S", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"R", "E", "C", "O", "R", "D", 8'h00, 8'h00, 8'h00},
      '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
   };
   localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd4, 4'd2, 4'd7, 4'd9, 4'd5, 4'd6, 4'd3};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE
   } ctl_state_type;

   typedef enum logic [2:0] {
      PS_LEAD,
      PS_TOKEN,
      PS_GAP,
      PS_SIGN,
      PS_DIGITS,
      PS_DONE,
      PS_FAIL
   } parse_state_type;

   typedef struct packed {
      logic store_byte;
      logic scan_start;
      logic scan_issue;
      logic load_rsp;
      logic clear_line;
   } ctl_cmd_type;

   typedef struct packed {
      logic is_cr;
      logic scan_end;
      logic hit;
      logic rsp_free;
   } ctl_status_type;

endpackage

>>> rtl/scld_ram.sv
// ----------------------------------------------------------------------------
// scld_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module scld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 20
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/scld_ctrl.sv
// ----------------------------------------------------------------------------
// scld_ctrl
// Sequencer: stores bytes, runs the line scan on carriage return and hands
// the decoded command to the output register.
// ----------------------------------------------------------------------------
module scld_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  scld_pkg::ctl_status_type status,
   output scld_pkg::ctl_cmd_type    cmd
);
   import scld_pkg::*;

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.is_cr) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_end) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!status.hit || status.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready      = 1'b1;
            cmd.store_byte = req_valid && !status.is_cr;
            cmd.scan_start = req_valid && status.is_cr;
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
         end
         ST_DRAIN: begin
         end
         ST_DECIDE: begin
            // wait for the output register only when there is a result
            cmd.load_rsp   = status.hit && status.rsp_free;
            cmd.clear_line = !status.hit || status.rsp_free;
         end
         default: begin
         end
      endcase
   end

endmodule

>>> rtl/scld_datapath.sv
// ----------------------------------------------------------------------------
// scld_datapath
// Line store, keyword match, GET number parse, address and output registers.
// ----------------------------------------------------------------------------
module scld_datapath #(
   parameter int LINE_DEPTH = 20
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [7:0]                req_rx_byte,
   input  scld_pkg::ctl_cmd_type     cmd,
   output scld_pkg::ctl_status_type  status,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [2:0]                rsp_command,
   output logic [7:0]                rsp_address,
   output logic                      rsp_address_updated
);
   import scld_pkg::*;

   localparam int LW = $clog2(LINE_DEPTH + 1);
   localparam int AW = $clog2(LINE_DEPTH);

   logic [LW-1:0]         length_ff, length_in;
   logic [LW-1:0]         idx_ff, idx_in;
   logic                  rd_valid_ff, rd_valid_in;
   logic [AW-1:0]         rd_pos_ff, rd_pos_in;
   logic [KW_COUNT-1:0]   alive_ff, alive_in;
   parse_state_type       pstate_ff, pstate_in;
   logic                  neg_ff, neg_in;
   logic [7:0]            acc_ff, acc_in;
   logic                  stop_ff, stop_in;
   logic [7:0]            addr_ff, addr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   command_type           rsp_command_ff, rsp_command_in;
   logic [7:0]            rsp_address_ff;
   logic                  rsp_updated_ff, rsp_updated_in;

   logic [7:0]            rd_data;
   logic                  wr_en;
   logic                  scan_end;
   logic                  issue;
   logic [KW_COUNT-1:0]   kw_ok;
   command_type           kw_cmd;
   logic                  is_blank, is_digit;
   logic [7:0]            digit;
   logic [7:0]            acc_x10;
   logic                  parse_ok;
   logic [7:0]            parse_val;

   assign wr_en    = cmd.store_byte && (length_ff < LW'(LINE_DEPTH));
   assign scan_end = (idx_ff == length_ff);
   assign issue    = cmd.scan_issue && !scan_end;

   scld_ram #(
      .WIDTH(8),
      .DEPTH(LINE_DEPTH)
   ) u_line_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(length_ff[AW-1:0]),
      .wr_data(req_rx_byte),
      .rd_addr(idx_ff[AW-1:0]),
      .rd_data(rd_data)
   );

   // keyword match: priority to the lowest code
   always_comb begin
      kw_cmd = CMD_PING;
      for (int k = 0; k < KW_COUNT; k++) begin
         kw_ok[k] = alive_ff[k] && (length_ff >= LW'(KW_LEN[k]));
      end
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (kw_ok[k]) kw_cmd = command_type'(3'(k));
      end
   end

   assign is_blank = (rd_data == 8'd32) || ((rd_data >= 8'd9) && (rd_data <= 8'd13));
   assign is_digit = (rd_data >= 8'h30) && (rd_data <= 8'h39);
   assign digit    = rd_data - 8'h30;
   assign acc_x10  = 8'((acc_ff << 3) + (acc_ff << 1));
   assign parse_ok = (pstate_ff == PS_DIGITS) || (pstate_ff == PS_DONE);
   assign parse_val = neg_ff ? 8'(8'd0 - acc_ff) : acc_ff;

   always_comb begin
      length_in    = length_ff;
      idx_in       = idx_ff;
      rd_valid_in  = issue;
      rd_pos_in    = idx_ff[AW-1:0];
      alive_in     = alive_ff;
      pstate_in    = pstate_ff;
      neg_in       = neg_ff;
      acc_in       = acc_ff;
      stop_in      = stop_ff;
      addr_in      = addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_command_in = kw_cmd;
      rsp_updated_in = 1'b0;

      if (wr_en) length_in = length_ff + 1'b1;

      if (cmd.scan_start) begin
         idx_in    = '0;
         alive_in  = '1;
         pstate_in = PS_LEAD;
         neg_in    = 1'b0;
         acc_in    = '0;
         stop_in   = 1'b0;
      end

      if (issue) idx_in = idx_ff + 1'b1;

      if (rd_valid_ff) begin
         for (int k = 0; k < KW_COUNT; k++) begin
            if ((rd_pos_ff < AW'(KW_LEN[k])) && (rd_data != KW_TEXT[k][rd_pos_ff[3:0]]))
               alive_in[k] = 1'b0;
         end
         // GET argument parse; a zero byte ends the parsed text
         if (!stop_ff) begin
            if (rd_data == 8'd0) begin
               stop_in = 1'b1;
            end else begin
               unique case (pstate_ff)
                  PS_LEAD: begin
                     if (!is_blank) pstate_in = PS_TOKEN;
                  end
                  PS_TOKEN: begin
                     if (is_blank) pstate_in = PS_GAP;
                  end
                  PS_GAP: begin
                     if (is_digit) begin
                        pstate_in = PS_DIGITS;
                        acc_in    = digit;
                     end else if (rd_data == "+" || rd_data == "-") begin
                        pstate_in = PS_SIGN;
                        neg_in    = (rd_data == "-");
                     end else if (!is_blank) begin
                        pstate_in = PS_FAIL;
                     end
                  end
                  PS_SIGN: begin
                     if (is_digit) begin
                        pstate_in = PS_DIGITS;
                        acc_in    = digit;
                     end else begin
                        pstate_in = PS_FAIL;
                     end
                  end
                  PS_DIGITS: begin
                     if (is_digit) acc_in = 8'(acc_x10 + digit);
                     else          pstate_in = PS_DONE;
                  end
                  PS_DONE, PS_FAIL: begin
                  end
                  default: pstate_in = PS_FAIL;
               endcase
            end
         end
      end

      if (cmd.load_rsp) begin
         rsp_valid_in   = 1'b1;
         rsp_updated_in = (kw_cmd == CMD_GET) && parse_ok;
         if (rsp_updated_in) addr_in = parse_val;
      end

      if (cmd.clear_line) length_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= '0;
         idx_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         length_ff    <= length_in;
         idx_ff       <= idx_in;
         rd_valid_ff  <= rd_valid_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_pos_ff <= rd_pos_in;
      alive_ff  <= alive_in;
      pstate_ff <= pstate_in;
      neg_ff    <= neg_in;
      acc_ff    <= acc_in;
      stop_ff   <= stop_in;
      if (cmd.load_rsp) begin
         rsp_command_ff <= rsp_command_in;
         rsp_address_ff <= addr_in;
         rsp_updated_ff <= rsp_updated_in;
      end
   end

   assign status.is_cr    = (req_rx_byte == CR_BYTE);
   assign status.scan_end = scan_end;
   assign status.hit      = |kw_ok;
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_command         = rsp_command_ff;
   assign rsp_address         = rsp_address_ff;
   assign rsp_address_updated = rsp_updated_ff;

endmodule

>>> rtl/serial_command_line_decoder.sv
// Storage: an ordinary byte is stored while the line is not full; a carriage
// return starts the scan (SCAN, DRAIN, DECIDE), and only a keyword match loads
// a result. Throughput: one byte per cycle between line ends; after a carriage
// return no byte is taken before DECIDE ends, nor while a previous result waits.
// Reset: synchronous, clears the line length, the stored address and the
// output valid; the line RAM holds no reset value.
// ----------------------------------------------------------------------------
// serial_command_line_decoder
// Collects received bytes into a line and decodes a command at each line end.
// ----------------------------------------------------------------------------
module serial_command_line_decoder #(
   parameter int LINE_DEPTH = 20
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_command,
   output logic [7:0] rsp_address,
   output logic       rsp_address_updated
);
   import scld_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type status;

   scld_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .status   (status),
      .cmd      (cmd)
   );

   scld_datapath #(
      .LINE_DEPTH(LINE_DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_rx_byte        (req_rx_byte),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_command        (rsp_command),
      .rsp_address        (rsp_address),
      .rsp_address_updated(rsp_address_updated)
   );

endmodule
